[hw/rtl/lars_pkg.sv]
// ---------------------------------------------------------------------------
// lars_pkg: shared types for the Life row step block
// Cell control, neighbor exchange and result entry types.
// ---------------------------------------------------------------------------
package lars_pkg;

  localparam int DATA_W = 64;
  localparam int GW_W   = 7;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic up;
    logic mid;
    logic row;
  } nbr_t;

  typedef struct packed {
    logic [DATA_W-1:0] cells;
    logic              last;
  } out_item_t;

endpackage

[hw/rtl/lars_cell.sv]
// ---------------------------------------------------------------------------
// lars_cell: one column of the Life row chain
// Holds the column's bits of the two previous rows, shares them with both
// neighbors and forms the next-generation bit for the row above and the row
// arriving now.
// ---------------------------------------------------------------------------
module lars_cell (
  input  logic              clk,
  input  logic              rst,
  input  lars_pkg::cell_ctrl_t ctrl,
  input  logic              en,
  input  logic              row_bit,
  input  lars_pkg::nbr_t    left,
  input  lars_pkg::nbr_t    right,
  output lars_pkg::nbr_t    self_bits,
  output logic              next_a,
  output logic              next_b
);
  import lars_pkg::*;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  logic upper;
  logic middle;
  logic [3:0] count_a;
  logic [3:0] count_b;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (ctrl.shift) begin
      upper  <= middle;
      middle <= row_bit;
    end
  end

  assign self_bits.up  = upper & en;
  assign self_bits.mid = middle & en;
  assign self_bits.row = row_bit & en;

  always_comb begin
    count_a = 4'($countones({left.up, self_bits.up, right.up,
                             left.row, self_bits.row, right.row,
                             left.mid, right.mid}));
    count_b = 4'($countones({left.mid, self_bits.mid, right.mid,
                             left.row, right.row}));
    next_a = en & ((count_a == BIRTH_COUNT) ||
                   ((count_a == SURVIVE_COUNT) && self_bits.mid));
    next_b = en & ((count_b == BIRTH_COUNT) ||
                   ((count_b == SURVIVE_COUNT) && self_bits.row));
  end

endmodule

[hw/rtl/lars_out_queue.sv]
// ---------------------------------------------------------------------------
// lars_out_queue: three-entry result queue
// Takes up to two results per cycle and presents the oldest on the output.
// ---------------------------------------------------------------------------
module lars_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_a,
  input  lars_pkg::out_item_t  item_a,
  input  logic                 push_b,
  input  lars_pkg::out_item_t  item_b,
  input  logic                 take,
  output logic                 has_room,
  output logic                 head_valid,
  output lars_pkg::out_item_t  head
);
  import lars_pkg::*;

  localparam int DEPTH = 3;

  out_item_t  q [DEPTH];
  out_item_t  q_next [DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] base;
  logic       pop;

  assign head_valid = (count != 2'd0);
  assign head       = q[0];
  assign has_room   = (count <= 2'd1);
  assign pop        = head_valid & take;

  always_comb begin
    base = count - {1'b0, pop};
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        q_next[i] = q[i+1];
      end else begin
        q_next[i] = q[i];
      end
      if (push_a && (base == 2'(i))) begin
        q_next[i] = item_a;
      end
      if (push_b && ((base + 2'd1) == 2'(i))) begin
        q_next[i] = item_b;
      end
    end
    count_next = base + {1'b0, push_a} + {1'b0, push_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

[hw/rtl/life_automaton_row_step.sv]
// ---------------------------------------------------------------------------
// life_automaton_row_step: one Life generation, one grid row per item
// A cell chain holds the two previous rows; each row but a frame's first yields
// the next generation of the row above, and the bottom row also its own.
// ---------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         tdata = row_cells[63:0], tlast = last_row
//  m_*      out        tdata = next_cells[63:0], tlast = frame_end
//  cfg_*    in         cfg_wr_data = grid_width[6:0], taken when cfg_wr_en
//
// One row is taken per cycle while the queue has room; its results are
// registered and appear on the next cycle. The bottom row gives two results,
// so the next row waits until one is taken. Input is taken while at most one
// result is queued, so a stalled output holds the input off once two results are
// waiting; the third queue entry takes the second result of a bottom row.
// Reset clears the held rows and the queue and sets grid_width to 64.
// ---------------------------------------------------------------------------
module life_automaton_row_step #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lars_pkg::DATA_W-1:0]  s_tdata,   // row_cells[63:0]
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lars_pkg::DATA_W-1:0]  m_tdata,   // next_cells[63:0]
  output logic                         m_tlast,
  input  logic                         cfg_wr_en,
  input  logic [lars_pkg::GW_W-1:0]    cfg_wr_data
);
  import lars_pkg::*;

  logic [GW_W-1:0]      grid_width;
  logic [1:0]           rows_held;
  logic [1:0]           rows_held_next;
  logic                 accept;
  cell_ctrl_t           ctrl;
  nbr_t                 self_bits [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] col_en;
  logic [MAX_WIDTH-1:0] next_a;
  logic [MAX_WIDTH-1:0] next_b;
  logic [DATA_W-1:0]    wide_a;
  logic [DATA_W-1:0]    wide_b;
  logic                 push_a;
  logic                 push_b;
  out_item_t            item_a;
  out_item_t            item_b;
  out_item_t            head;
  logic                 has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GW_W'(64);
    end else if (cfg_wr_en) begin
      grid_width <= cfg_wr_data;
    end
  end

  assign s_tready = has_room;
  assign accept   = s_tvalid & has_room;

  assign ctrl.shift = accept & ~s_tlast;
  assign ctrl.clear = accept & s_tlast;

  always_comb begin
    rows_held_next = rows_held;
    if (ctrl.clear) begin
      rows_held_next = 2'd0;
    end else if (ctrl.shift) begin
      rows_held_next = (rows_held == 2'd0) ? 2'd1 : 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held <= 2'd0;
    end else begin
      rows_held <= rows_held_next;
    end
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_col
    nbr_t left;
    nbr_t right;

    assign col_en[k] = (GW_W'(k) < grid_width);

    if (k == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lo_n
      assign left = self_bits[k-1];
    end

    if (k == MAX_WIDTH - 1) begin : g_hi
      assign right = '0;
    end else begin : g_hi_n
      assign right = self_bits[k+1];
    end

    lars_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .en        (col_en[k]),
      .row_bit   (s_tdata[k]),
      .left      (left),
      .right     (right),
      .self_bits (self_bits[k]),
      .next_a    (next_a[k]),
      .next_b    (next_b[k])
    );
  end

  if (MAX_WIDTH < DATA_W) begin : g_pad
    assign wide_a = {{(DATA_W - MAX_WIDTH){1'b0}}, next_a};
    assign wide_b = {{(DATA_W - MAX_WIDTH){1'b0}}, next_b};
  end else begin : g_full
    assign wide_a = next_a;
    assign wide_b = next_b;
  end

  // With no rows held the middle row is dead, so the second-result cells give
  // the single-row result directly.
  always_comb begin
    push_a = accept & ((rows_held != 2'd0) | s_tlast);
    push_b = accept & (rows_held != 2'd0) & s_tlast;
    if (rows_held != 2'd0) begin
      item_a.cells = wide_a;
      item_a.last  = 1'b0;
    end else begin
      item_a.cells = wide_b;
      item_a.last  = 1'b1;
    end
    item_b.cells = wide_b;
    item_b.last  = 1'b1;
  end

  lars_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (push_a),
    .item_a     (item_a),
    .push_b     (push_b),
    .item_b     (item_b),
    .take       (m_tready),
    .has_room   (has_room),
    .head_valid (m_tvalid),
    .head       (head)
  );

  assign m_tdata = head.cells;
  assign m_tlast = head.last;

endmodule

[hw/rtl/lars_checker.sv]
// ---------------------------------------------------------------------------
// lars_checker: port-level checks for the Life row step block
// Watches the stream and configuration ports and flags illegal behavior.
// ---------------------------------------------------------------------------
module lars_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic                         s_tlast,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [lars_pkg::DATA_W-1:0]  m_tdata,
  input  logic                         m_tlast,
  input  logic                         cfg_wr_en,
  input  logic [lars_pkg::GW_W-1:0]    cfg_wr_data
);
  import lars_pkg::*;

  logic [GW_W-1:0]   width_seen;
  logic [DATA_W-1:0] dead_cols;
  logic              in_item;

  assign in_item = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen <= GW_W'(64);
    end else if (cfg_wr_en) begin
      width_seen <= cfg_wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < DATA_W; k++) begin
      dead_cols[k] = (GW_W'(k) >= width_seen);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_dead_cols: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata & dead_cols) == '0))
    else $error("live cell beyond grid width");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input held off with no result pending");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    in_item && s_tlast |=> m_tvalid)
    else $error("bottom row gave no result");

endmodule

bind life_automaton_row_step lars_checker u_lars_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .s_tlast     (s_tlast),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata),
  .m_tlast     (m_tlast),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

[tb/life_automaton_row_step_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// life_automaton_row_step_test: self-checking bench for the Life row step
// Streams grid rows through the block under several width settings and
// idle patterns, predicts each next-generation row from its own copy of the
// held rows, and compares every output item against the oldest prediction.
// ---------------------------------------------------------------------------
module life_automaton_row_step_test;

  import lars_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 14;
  localparam int ROWS_PER_PHASE = 100;

  typedef struct packed {
    logic [DATA_W-1:0] cells;
    logic              last;
  } row_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              cfg_wr_en = 1'b0;
  logic [GW_W-1:0]   cfg_wr_data = '0;

  row_item_t   row_queue[$];
  out_item_t   expected_rows[$];
  row_item_t   driver_row;
  out_item_t   seen_row;

  logic [GW_W-1:0]   width_setting = 7'd64;
  logic [DATA_W-1:0] upper_cells = '0;
  logic [DATA_W-1:0] middle_cells = '0;
  logic              frame_open = 1'b0;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int error_count = 0;

  life_automaton_row_step u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] column_mask(input logic [GW_W-1:0] w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [DATA_W-1:0] next_generation(input logic [DATA_W-1:0] above,
                                                         input logic [DATA_W-1:0] here,
                                                         input logic [DATA_W-1:0] below);
    logic [DATA_W-1:0] mask, a, h, b, result;
    int count, k, col;
    mask = column_mask(width_setting);
    a = above & mask;
    h = here & mask;
    b = below & mask;
    result = '0;
    for (k = 0; k < DATA_W; k++) begin
      count = 0;
      for (col = k - 1; col <= k + 1; col++) begin
        if (col >= 0 && col < DATA_W) begin
          count += int'(a[col]);
          count += int'(b[col]);
          if (col != k) count += int'(h[col]);
        end
      end
      result[k] = (count == 3) || (count == 2 && h[k]);
    end
    return result & mask;
  endfunction

  function automatic void push_result(input logic [DATA_W-1:0] cells, input logic last);
    out_item_t entry;
    entry.cells = cells;
    entry.last = last;
    expected_rows.push_back(entry);
  endfunction

  function automatic void predict_row(input logic [DATA_W-1:0] cells, input logic last);
    if (!frame_open) begin
      if (last) begin
        push_result(next_generation('0, cells, '0), 1'b1);
      end else begin
        upper_cells = '0;
        middle_cells = cells;
        frame_open = 1'b1;
      end
    end else begin
      push_result(next_generation(upper_cells, middle_cells, cells), 1'b0);
      if (last) begin
        push_result(next_generation(middle_cells, cells, '0), 1'b1);
        upper_cells = '0;
        middle_cells = '0;
        frame_open = 1'b0;
      end else begin
        upper_cells = middle_cells;
        middle_cells = cells;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_row(s_tdata, s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (row_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          driver_row = row_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= driver_row.cells;
          s_tlast <= driver_row.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item, expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        seen_row = expected_rows.pop_front();
        if (m_tdata !== seen_row.cells) begin
          error_count++;
          $display("%0t: next_cells mismatch, expected %h, actual %h",
                   $time, seen_row.cells, m_tdata);
        end
        if (m_tlast !== seen_row.last) begin
          error_count++;
          $display("%0t: frame_end mismatch, expected %b, actual %b",
                   $time, seen_row.last, m_tlast);
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (row_queue.size() > 0 || s_tvalid || expected_rows.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_width(input logic [GW_W-1:0] w);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_setting = w;
    @(negedge clk);
  endtask

  task automatic queue_row(input logic [DATA_W-1:0] cells, input logic last);
    row_item_t entry;
    entry.cells = cells;
    entry.last = last;
    row_queue.push_back(entry);
  endtask

  function automatic logic [DATA_W-1:0] random_row();
    logic [DATA_W-1:0] r1, r2, r3;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    r3 = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return r1 & r2 & r3;
      5: return r1 | r2;
      default: return r1;
    endcase
  endfunction

  initial begin
    logic [GW_W-1:0] phase_widths[PHASES];
    int phase, rows_left, frame_len, r;

    phase_widths = '{7'd64, 7'd1, 7'd2, 7'd63, 7'd3, 7'd33, 7'd17,
                     7'd64, 7'd5, 7'd48, 7'd64, 7'd7, 7'd1, 7'd64};
    phase_widths[5] = 7'($urandom_range(1, 64));
    phase_widths[9] = 7'($urandom_range(1, 64));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows at the reset width, then the width extremes.
    queue_row('1, 1'b1);
    queue_row('0, 1'b1);
    queue_row('1, 1'b0);
    queue_row(64'h8000_0000_0000_0001, 1'b0);
    queue_row(64'h5555_5555_5555_5555, 1'b0);
    queue_row('1, 1'b1);
    queue_row('0, 1'b0);
    queue_row(64'h0000_0000_0070_0000, 1'b0);
    queue_row('0, 1'b1);
    queue_row(64'hC000_0000_0000_0003, 1'b0);
    queue_row(64'hC000_0000_0000_0003, 1'b0);
    queue_row(64'hC000_0000_0000_0003, 1'b1);
    wait_idle();
    set_width(7'd0);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);
    wait_idle();
    set_width(7'd127);
    queue_row('1, 1'b0);
    queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row('1, 1'b1);
    wait_idle();
    set_width(7'd65);
    queue_row('1, 1'b1);
    wait_idle();
    set_width(7'd64);
    queue_row('1, 1'b0);
    queue_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    // The width drops while two rows of the frame are held.
    wait_idle();
    set_width(7'd5);
    queue_row('1, 1'b1);
    wait_idle();
    set_width(7'd1);
    queue_row('1, 1'b0);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      set_width(phase_widths[phase]);
      if (phase < 5) begin
        sender_idle_pct = 19;
        receiver_idle_pct = 79;
      end else if (phase < 10) begin
        sender_idle_pct = 79;
        receiver_idle_pct = 19;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (phase == 10 || phase == 12) hold_req = ~hold_req;
      rows_left = ROWS_PER_PHASE;
      while (rows_left > 0) begin
        case ($urandom_range(9))
          0: frame_len = 1;
          1: frame_len = $urandom_range(20, 40);
          default: frame_len = $urandom_range(2, 8);
        endcase
        for (r = 0; r < frame_len; r++) begin
          queue_row(random_row(), r == frame_len - 1);
        end
        rows_left -= frame_len;
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
